>>> sv/rcef_pkg.sv
package rcef_pkg;

  // Template characters
  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChDec     = 8'h64;  // 'd'
  localparam logic [7:0] ChThree   = 8'h33;  // '3'
  localparam logic [7:0] ChTwo     = 8'h32;  // '2'
  localparam logic [7:0] ChDot     = 8'h2e;  // '.'
  localparam logic [7:0] ChPlus    = 8'h2b;  // '+'
  localparam logic [7:0] ChMinus   = 8'h2d;  // '-'
  localparam logic [7:0] ChZero    = 8'h30;  // '0', also the digit OR mask

  // Depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // How the back end expands one command into characters
  typedef enum logic [1:0] {
    KIND_ONE,        // c0 only
    KIND_TWO_SMALL,  // tens and ones of rem
    KIND_TWO_DIV,    // c0, then rem as a digit
    KIND_THREE       // c0, then tens and ones of rem
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] c0;
    logic [6:0] rem;
  } cmd_t;

  // Tens digit of a value below 100
  function automatic logic [3:0] dec_tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  // Ones digit of a value below 100
  function automatic logic [3:0] dec_ones(input logic [6:0] v);
    logic [6:0] t10;
    t10 = 7'(dec_tens(v)) * 7'd10;
    return 4'(v - t10);
  endfunction

endpackage

>>> sv/rcef_front.sv
module rcef_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         ch_i,
  input  logic               start_req_i,
  input  logic [15:0]        start_count_i,
  output logic               full_o,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rcef_pkg::cmd_t     q_cmd_o
);

  localparam logic [63:0] Pow = 64'd1 << COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] Recip10  = COUNT_WIDTH'(Pow / 10);
  localparam logic [COUNT_WIDTH-1:0] Recip100 = COUNT_WIDTH'(Pow / 100);
  localparam logic [COUNT_WIDTH-1:0] Ten      = COUNT_WIDTH'(10);
  localparam logic [COUNT_WIDTH-1:0] Hundred  = COUNT_WIDTH'(100);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_ADD,
    MODE_SUB
  } mode_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_FIX
  } state_e;

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] quot_q, quot_d;
  logic                   sel100_q, sel100_d;

  logic                     accept;
  mode_e                    mode_eff;
  logic [COUNT_WIDTH-1:0]   cnt_eff;
  logic                     lt10, lt100;
  logic [2*COUNT_WIDTH-1:0] prod;
  logic [COUNT_WIDTH-1:0]   qd, rem0, rem1, quot_fix, div_const;

  assign full_o = (state_q != ST_RUN) || q_full_i;
  assign accept = push_i && !full_o;

  // Start request reloads the count and leaves escape mode
  assign cnt_eff  = start_req_i ? COUNT_WIDTH'(start_count_i) : count_q;
  assign mode_eff = start_req_i ? MODE_NORMAL : mode_q;
  assign lt10     = cnt_eff < Ten;
  assign lt100    = cnt_eff < Hundred;

  // Reciprocal estimate of the quotient, low by at most one
  assign prod = {{COUNT_WIDTH{1'b0}}, count_q} *
                {{COUNT_WIDTH{1'b0}}, (sel100_q ? Recip100 : Recip10)};

  // Remainder of the estimate, then one correction step
  assign div_const = sel100_q ? Hundred : Ten;
  assign qd        = sel100_q ? ((quot_q << 6) + (quot_q << 5) + (quot_q << 2))
                              : ((quot_q << 3) + (quot_q << 1));
  assign rem0      = count_q - qd;
  assign rem1      = (rem0 >= div_const) ? (rem0 - div_const) : rem0;
  assign quot_fix  = (rem0 >= div_const) ? (quot_q + 1'b1) : quot_q;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    count_d  = count_q;
    quot_d   = quot_q;
    sel100_d = sel100_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{kind: rcef_pkg::KIND_ONE, c0: ch_i, rem: cnt_eff[6:0]};

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          count_d = cnt_eff;
          mode_d  = MODE_NORMAL;
          unique case (mode_eff)
            MODE_NORMAL: begin
              if (ch_i == rcef_pkg::ChPercent) begin
                mode_d = MODE_ESC;
              end else begin
                q_push_o = 1'b1;
              end
            end
            MODE_ADD: count_d = cnt_eff + COUNT_WIDTH'(ch_i);
            MODE_SUB: count_d = cnt_eff - COUNT_WIDTH'(ch_i);
            MODE_ESC: begin
              priority if (ch_i == rcef_pkg::ChDec) begin
                if (lt10) begin
                  q_push_o   = 1'b1;
                  q_cmd_o.c0 = rcef_pkg::ChZero | {4'h0, cnt_eff[3:0]};
                end else if (lt100) begin
                  q_push_o     = 1'b1;
                  q_cmd_o.kind = rcef_pkg::KIND_TWO_SMALL;
                end else begin
                  sel100_d = 1'b1;
                  state_d  = ST_MUL;
                end
              end else if (ch_i == rcef_pkg::ChThree) begin
                if (lt100) begin
                  q_push_o     = 1'b1;
                  q_cmd_o.kind = rcef_pkg::KIND_THREE;
                  q_cmd_o.c0   = rcef_pkg::ChZero;
                end else begin
                  sel100_d = 1'b1;
                  state_d  = ST_MUL;
                end
              end else if (ch_i == rcef_pkg::ChTwo) begin
                if (lt100) begin
                  q_push_o     = 1'b1;
                  q_cmd_o.kind = rcef_pkg::KIND_TWO_SMALL;
                end else begin
                  sel100_d = 1'b0;
                  state_d  = ST_MUL;
                end
              end else if (ch_i == rcef_pkg::ChDot) begin
                q_push_o   = 1'b1;
                q_cmd_o.c0 = cnt_eff[7:0];
              end else if (ch_i == rcef_pkg::ChPlus) begin
                mode_d = MODE_ADD;
              end else if (ch_i == rcef_pkg::ChMinus) begin
                mode_d = MODE_SUB;
              end else begin
                q_push_o = 1'b1;
              end
            end
            default: mode_d = MODE_NORMAL;
          endcase
        end
      end
      ST_MUL: begin
        quot_d  = prod[2*COUNT_WIDTH-1:COUNT_WIDTH];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        // Queue had room at accept and only drained since
        q_push_o     = 1'b1;
        q_cmd_o.kind = sel100_q ? rcef_pkg::KIND_THREE : rcef_pkg::KIND_TWO_DIV;
        q_cmd_o.c0   = quot_fix[7:0] | rcef_pkg::ChZero;
        q_cmd_o.rem  = rem1[6:0];
        if (sel100_q) begin
          count_d = COUNT_WIDTH'(rem1[6:0]);
        end
        state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Hold state, mode, count and divider registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      mode_q   <= MODE_NORMAL;
      count_q  <= '0;
      sel100_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      count_q  <= count_d;
      sel100_q <= sel100_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

endmodule

>>> sv/rcef_queue.sv
module rcef_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcef_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rcef_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(rcef_pkg::QueueDepth);
  localparam logic [PtrW:0] DepthN = (PtrW + 1)'(rcef_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(rcef_pkg::QueueDepth - 1);

  rcef_pkg::cmd_t mem_q [rcef_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   fill_q;
  logic            do_push, do_pop;

  assign full_o  = fill_q == DepthN;
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      end
      fill_q <= fill_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/rcef_back.sv
module rcef_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  rcef_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     out_char_o,
  output logic           last_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  logic [7:0] char_q;
  logic       last_q;

  logic       load;
  logic [7:0] sel_char;
  logic [1:0] last_idx;
  logic [7:0] tens_ch, ones_ch;

  assign tens_ch = rcef_pkg::ChZero | {4'h0, rcef_pkg::dec_tens(q_head_i.rem)};
  assign ones_ch = rcef_pkg::ChZero | {4'h0, rcef_pkg::dec_ones(q_head_i.rem)};

  // Pick the character at the current position of the head command
  always_comb begin
    sel_char = q_head_i.c0;
    last_idx = 2'd0;
    unique case (q_head_i.kind)
      rcef_pkg::KIND_ONE: begin
        sel_char = q_head_i.c0;
        last_idx = 2'd0;
      end
      rcef_pkg::KIND_TWO_SMALL: begin
        sel_char = (idx_q == 2'd0) ? tens_ch : ones_ch;
        last_idx = 2'd1;
      end
      rcef_pkg::KIND_TWO_DIV: begin
        sel_char = (idx_q == 2'd0) ? q_head_i.c0
                                   : (rcef_pkg::ChZero | {4'h0, q_head_i.rem[3:0]});
        last_idx = 2'd1;
      end
      rcef_pkg::KIND_THREE: begin
        sel_char = (idx_q == 2'd0) ? q_head_i.c0 : ((idx_q == 2'd1) ? tens_ch : ones_ch);
        last_idx = 2'd2;
      end
      default: begin
        sel_char = q_head_i.c0;
        last_idx = 2'd0;
      end
    endcase
  end

  assign load    = (!valid_q || pop_i) && !q_empty_i;
  assign q_pop_o = load && (idx_q == last_idx);

  assign empty_o    = !valid_q;
  assign out_char_o = char_q;
  assign last_o     = last_q;

  // Advance through the head command, one character per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= (idx_q == last_idx) ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= sel_char;
      last_q <= idx_q == last_idx;
    end
  end

endmodule

>>> sv/repeat_count_escape_formatter.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | push / full          | ch_i, start_req_i, start_count_i
// result   | empty / pop          | out_char_o, last_o
//
// A plain character or short escape is taken without holding the input; an escape
// that needs a decimal split of a count of 100 or more holds full while the
// reciprocal multiplier and its correction step run.
// Results leave one per cycle from the output register while pop is high and the
// queue holds commands; a two-entry queue lets both sides stall on their own.
// Reset clears mode, count and the queue pointers and fill level.
module repeat_count_escape_formatter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        start_req_i,
  input  logic [15:0] start_count_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  logic           q_push, q_full, q_pop, q_empty;
  rcef_pkg::cmd_t q_cmd, q_head;

  rcef_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ch_i          (ch_i),
    .start_req_i   (start_req_i),
    .start_count_i (start_count_i),
    .full_o        (full),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  rcef_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  rcef_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

endmodule

>>> sv/rcef_checker.sv
module rcef_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       last_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_o)))
    else $error("stalled result changed");

  // A taken character that is not the last is followed at once by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a multi-character result");

  // Input must not stay blocked while the result side has nothing to deliver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && empty) ##1 (full && empty) |=> !(full && empty))
    else $error("input blocked while result side idles");

endmodule

bind repeat_count_escape_formatter rcef_checker u_rcef_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .last_o     (last_o)
);
